@@ rtl/sacc_pkg.sv @@
// Shared constants and types for the set-associative cache with clock replacement.
package sacc_pkg;

   // Fixed widths of the stream and configuration payloads.
   localparam int ADDRESS_W   = 32;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 16;
   localparam int WAY_OUT_W   = 3;
   localparam int SET_OUT_W   = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   // Largest usable number of index bits.
   localparam int MAX_INDEX_BITS = 8;

   // Parameter defaults.
   localparam int NUM_SETS_DEFAULT   = 256;
   localparam int MAX_WAYS_DEFAULT   = 8;
   localparam int ADDR_WIDTH_DEFAULT = 32;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_INDEX_BITS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_OFFSET_BITS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WAYS_IN_USE = 2'd2;

   // Configuration reset values.
   localparam logic [CSR_DATA_W-1:0] INDEX_BITS_RESET  = 4'd6;
   localparam logic [CSR_DATA_W-1:0] OFFSET_BITS_RESET = 4'd6;
   localparam logic [CSR_DATA_W-1:0] WAYS_RESET        = 4'd4;

   // What the way probe reports about the way under the cursor.
   typedef struct packed {
      logic match;
      logic referenced;
   } probe_type;

endpackage

@@ rtl/sacc_ram.sv @@
// Single-port-write, single-port-read row memory with a registered read.
module sacc_ram
   import sacc_pkg::*;
#(
   parameter int DEPTH  = NUM_SETS_DEFAULT,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sacc_probe.sv @@
// Shared way unit: looks at the way under the cursor and reports tag match and reference bit.
module sacc_probe
   import sacc_pkg::*;
#(
   parameter int MAX_WAYS   = MAX_WAYS_DEFAULT,
   parameter int ADDR_WIDTH = ADDR_WIDTH_DEFAULT,
   parameter int WAY_W      = 3
) (
   input  logic [MAX_WAYS*ADDR_WIDTH-1:0] row_tags,
   input  logic [MAX_WAYS-1:0]            row_valid,
   input  logic [MAX_WAYS-1:0]            row_ref,
   input  logic [WAY_W-1:0]               cursor,
   input  logic [ADDR_WIDTH-1:0]          tag,
   output probe_type                      probe
);

   logic [ADDR_WIDTH-1:0] tag_arr [MAX_WAYS];

   for (genvar w = 0; w < MAX_WAYS; w++) begin : g_unpack
      assign tag_arr[w] = row_tags[w*ADDR_WIDTH +: ADDR_WIDTH];
   end

   always_comb begin
      probe.match      = row_valid[cursor] && (tag_arr[cursor] == tag);
      probe.referenced = row_ref[cursor];
   end

endmodule

@@ rtl/set_assoc_cache_clock_replace.sv @@
// Top level of the set-associative cache tag array with clock replacement.
//
// Each request item carries one byte address; the block splits it into set and tag, searches
// the set one way per cycle through a single shared probe, and on a miss walks the clock hand
// one way per cycle, clearing reference bits until it finds a victim. One response item
// (hit, way, set) comes back per request. A new request is taken only once the previous one
// has been written back and its response registered, and the write-back waits while the
// response register still holds an item that has not been taken. After reset a clearing
// pass writes every set row once before the first request is taken; configuration writes
// are accepted at any time.
module set_assoc_cache_clock_replace
   import sacc_pkg::*;
#(
   parameter int NUM_SETS   = NUM_SETS_DEFAULT,
   parameter int MAX_WAYS   = MAX_WAYS_DEFAULT,
   parameter int ADDR_WIDTH = ADDR_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [31:0] address
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [0] hit, [3:1] way, [11:4] set_index, rest 0
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
   localparam int SETX_W  = (SET_W > SET_OUT_W) ? SET_W : SET_OUT_W;
   localparam int ADDRX_W = (ADDR_WIDTH > ADDRESS_W) ? ADDR_WIDTH : ADDRESS_W;
   localparam int TAGS_W  = MAX_WAYS * ADDR_WIDTH;
   localparam int ROW_W   = TAGS_W + 2 * MAX_WAYS + WAY_W;
   localparam int SUM_W   = 5;

   localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SETUP  = 3'd2;
   localparam logic [2:0] ST_LOOKUP = 3'd3;
   localparam logic [2:0] ST_FETCH  = 3'd4;
   localparam logic [2:0] ST_SEARCH = 3'd5;
   localparam logic [2:0] ST_SCAN   = 3'd6;
   localparam logic [2:0] ST_WRITE  = 3'd7;

   // Reduces the extracted index modulo the number of sets by conditional subtraction.
   function automatic logic [SET_OUT_W-1:0] reduce_set(input logic [SET_OUT_W-1:0] v);
      logic [SET_OUT_W-1:0] r;
      r = v;
      for (int k = SET_OUT_W - 1; k >= 0; k--) begin
         if (int'(r) >= (NUM_SETS << k)) begin
            r = r - SET_OUT_W'(NUM_SETS << k);
         end
      end
      return r;
   endfunction

   logic [2:0]            state_ff, state_in;
   logic [SET_W-1:0]      clr_ptr_ff, clr_ptr_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic [ADDR_WIDTH-1:0] tag_ff, tag_in;
   logic [SET_W-1:0]      set_ff, set_in;
   logic [SET_OUT_W-1:0]  set8_ff, set8_in;
   logic [MAX_WAYS-1:0]   valid_ff, valid_in;
   logic [MAX_WAYS-1:0]   ref_ff, ref_in;
   logic [WAY_W-1:0]      hand_ff, hand_in;
   logic [WAY_W-1:0]      cursor_ff, cursor_in;
   logic                  hit_ff, hit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [CSR_DATA_W-1:0] index_bits_ff, offset_bits_ff, ways_ff;

   logic                  mem_wr_en, mem_rd_en;
   logic [SET_W-1:0]      mem_wr_addr;
   logic [ROW_W-1:0]      mem_wr_data, mem_rd_data;
   logic [TAGS_W-1:0]     rd_tags, wr_tags;

   logic [CSR_DATA_W-1:0] ib_eff;
   logic [WCNT_W-1:0]     ways_eff;
   logic [WAY_W-1:0]      last_way, cursor_next, hand_start;
   logic [ADDRX_W-1:0]    addr_wide;
   logic [ADDR_WIDTH-1:0] shifted;
   logic [SET_OUT_W-1:0]  index_mask, set_reduced;
   logic [SETX_W-1:0]     set_wide;
   logic [ADDR_WIDTH-1:0] tag_arr [MAX_WAYS];
   probe_type             probe;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff  <= INDEX_BITS_RESET;
         offset_bits_ff <= OFFSET_BITS_RESET;
         ways_ff        <= WAYS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_INDEX_BITS:  index_bits_ff  <= csr_data;
            REG_OFFSET_BITS: offset_bits_ff <= csr_data;
            REG_WAYS_IN_USE: ways_ff        <= csr_data;
            default: ;
         endcase
      end
   end

   // Effective configuration.
   always_comb begin
      ib_eff = (int'(index_bits_ff) > MAX_INDEX_BITS) ? CSR_DATA_W'(MAX_INDEX_BITS)
                                                       : index_bits_ff;
      if (ways_ff == '0) begin
         ways_eff = WCNT_W'(1);
      end else if (int'(ways_ff) > MAX_WAYS) begin
         ways_eff = WCNT_W'(MAX_WAYS);
      end else begin
         ways_eff = WCNT_W'(ways_ff);
      end
      last_way    = WAY_W'(ways_eff - 1'b1);
      cursor_next = (cursor_ff == last_way) ? '0 : WAY_W'(cursor_ff + 1'b1);
      // A hand left beyond the ways in use after a reconfiguration restarts at way zero.
      hand_start  = (WCNT_W'(hand_ff) >= ways_eff) ? '0 : hand_ff;
   end

   // Address split.
   always_comb begin
      addr_wide   = ADDRX_W'(req_tdata);
      shifted     = addr_ff >> offset_bits_ff;
      index_mask  = SET_OUT_W'((9'd1 << ib_eff) - 9'd1);
      set_reduced = reduce_set(shifted[SET_OUT_W-1:0] & index_mask);
      set_wide    = SETX_W'(set_reduced);
   end

   // Row memory: tags, valid bits, reference bits and the clock hand of one set.
   sacc_ram #(
      .DEPTH  (NUM_SETS),
      .WIDTH  (ROW_W),
      .ADDR_W (SET_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (set_ff),
      .rd_data (mem_rd_data)
   );

   assign rd_tags = mem_rd_data[TAGS_W-1:0];

   sacc_probe #(
      .MAX_WAYS   (MAX_WAYS),
      .ADDR_WIDTH (ADDR_WIDTH),
      .WAY_W      (WAY_W)
   ) u_probe (
      .row_tags  (rd_tags),
      .row_valid (valid_ff),
      .row_ref   (ref_ff),
      .cursor    (cursor_ff),
      .tag       (tag_ff),
      .probe     (probe)
   );

   // On a miss the victim way takes the new tag.
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         tag_arr[w] = rd_tags[w*ADDR_WIDTH +: ADDR_WIDTH];
         if (!hit_ff && (cursor_ff == WAY_W'(w))) begin
            tag_arr[w] = tag_ff;
         end
         wr_tags[w*ADDR_WIDTH +: ADDR_WIDTH] = tag_arr[w];
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_ptr_in   = clr_ptr_ff;
      addr_in      = addr_ff;
      tag_in       = tag_ff;
      set_in       = set_ff;
      set8_in      = set8_ff;
      valid_in     = valid_ff;
      ref_in       = ref_ff;
      hand_in      = hand_ff;
      cursor_in    = cursor_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = set_ff;
      mem_wr_data  = {hand_ff, ref_ff, valid_ff, wr_tags};
      mem_rd_en    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ptr_ff;
            mem_wr_data = '0;
            if (clr_ptr_ff == LAST_SET) begin
               state_in = ST_IDLE;
            end else begin
               clr_ptr_in = SET_W'(clr_ptr_ff + 1'b1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               addr_in  = addr_wide[ADDR_WIDTH-1:0];
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            set8_in  = set_reduced;
            set_in   = set_wide[SET_W-1:0];
            tag_in   = addr_ff >> (SUM_W'(ib_eff) + SUM_W'(offset_bits_ff));
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            mem_rd_en = 1'b1;
            state_in  = ST_FETCH;
         end
         ST_FETCH: begin
            valid_in  = mem_rd_data[TAGS_W +: MAX_WAYS];
            ref_in    = mem_rd_data[TAGS_W + MAX_WAYS +: MAX_WAYS];
            hand_in   = mem_rd_data[TAGS_W + 2*MAX_WAYS +: WAY_W];
            cursor_in = '0;
            hit_in    = 1'b0;
            state_in  = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (probe.match) begin
               hit_in            = 1'b1;
               ref_in[cursor_ff] = 1'b1;
               state_in          = ST_WRITE;
            end else if (cursor_ff == last_way) begin
               cursor_in = hand_start;
               state_in  = ST_SCAN;
            end else begin
               cursor_in = cursor_next;
            end
         end
         ST_SCAN: begin
            if (!probe.referenced) begin
               valid_in[cursor_ff] = 1'b1;
               ref_in[cursor_ff]   = 1'b1;
               hand_in             = cursor_next;
               state_in            = ST_WRITE;
            end else begin
               // Second chance: clear the bit and move on.
               ref_in[cursor_ff] = 1'b0;
               cursor_in         = cursor_next;
            end
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               mem_wr_en    = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_W - 1 - WAY_OUT_W - SET_OUT_W){1'b0}},
                               set8_ff, WAY_OUT_W'(cursor_ff), hit_ff};
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      tag_ff      <= tag_in;
      set_ff      <= set_in;
      set8_ff     <= set8_in;
      valid_ff    <= valid_in;
      ref_ff      <= ref_in;
      hand_ff     <= hand_in;
      cursor_ff   <= cursor_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A new response is only produced by the write-back step.
   a_rsp_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_WRITE))
      else $error("response raised outside write-back");

   // The clock walk never leaves the ways in use.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (WCNT_W'(cursor_ff) < ways_eff))
      else $error("clock hand outside the ways in use");

   // The way written back is always valid and referenced.
   a_write_way_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |-> (valid_ff[cursor_ff] && ref_ff[cursor_ff]))
      else $error("written way is not valid and referenced");

endmodule

@@ tb/sv/tb_set_assoc_cache_clock_replace.sv @@
// Testbench for the set-associative cache tag array with clock replacement.
`timescale 1ns / 1ps

module tb_set_assoc_cache_clock_replace;
   import sacc_pkg::*;

   localparam int SETS          = NUM_SETS_DEFAULT;
   localparam int WAYS_MAX      = MAX_WAYS_DEFAULT;
   localparam int DRAIN_CYCLES  = 40;
   localparam int WATCHDOG_MAX  = 5000;

   typedef struct packed {
      logic [SET_OUT_W-1:0] set_index;
      logic [WAY_OUT_W-1:0] way;
      logic                 hit;
   } lookup_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Predictor copy of the configuration and the cache state.
   logic [CSR_DATA_W-1:0] cfg_index_bits = INDEX_BITS_RESET;
   logic [CSR_DATA_W-1:0] cfg_offset_bits = OFFSET_BITS_RESET;
   logic [CSR_DATA_W-1:0] cfg_ways = WAYS_RESET;
   bit                    line_valid [SETS*WAYS_MAX];
   logic [31:0]           line_tag   [SETS*WAYS_MAX];
   bit                    line_ref   [SETS*WAYS_MAX];
   bit   [2:0]            clock_hand [SETS];

   logic [31:0]       address_backlog[$];
   lookup_result_type predicted_lookups[$];
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                error_count = 0;
   int                quiet_cycles = 0;

   set_assoc_cache_clock_replace i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [31:0] address
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [0] hit, [3:1] way, [11:4] set_index, rest 0
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned active_ways();
      int unsigned w;
      w = cfg_ways;
      if (w == 0) w = 1;
      if (w > WAYS_MAX) w = WAYS_MAX;
      return w;
   endfunction

   function automatic int unsigned active_index_bits();
      return (cfg_index_bits > MAX_INDEX_BITS) ? MAX_INDEX_BITS : cfg_index_bits;
   endfunction

   // Looks the address up in the predicted state and applies hit or clock replacement.
   function automatic lookup_result_type cache_lookup(input logic [31:0] addr);
      int unsigned       ib;
      int unsigned       ob;
      int unsigned       ways;
      int unsigned       set;
      int unsigned       base;
      int unsigned       hand;
      logic [31:0]       tag;
      lookup_result_type r;
      ib   = active_index_bits();
      ob   = cfg_offset_bits;
      ways = active_ways();
      set  = (addr >> ob) & ((32'd1 << ib) - 1);
      tag  = addr >> (ib + ob);
      base = set * WAYS_MAX;
      r.hit       = 1'b0;
      r.way       = '0;
      r.set_index = set[SET_OUT_W-1:0];
      for (int unsigned w = 0; w < ways; w++) begin
         if (!r.hit && line_valid[base+w] && line_tag[base+w] == tag) begin
            line_ref[base+w] = 1'b1;
            r.hit = 1'b1;
            r.way = w[WAY_OUT_W-1:0];
         end
      end
      if (!r.hit) begin
         hand = clock_hand[set];
         if (hand >= ways) hand = 0;
         // Second chance: referenced ways lose their bit and are passed over.
         while (line_ref[base+hand]) begin
            line_ref[base+hand] = 1'b0;
            hand = (hand + 1) % ways;
         end
         clock_hand[set] = 3'((hand + 1) % ways);
         line_valid[base+hand] = 1'b1;
         line_tag[base+hand]   = tag;
         line_ref[base+hand]   = 1'b1;
         r.way = hand[WAY_OUT_W-1:0];
      end
      return r;
   endfunction

   // Request driver; the expected lookup is formed when an item is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_lookups.push_back(cache_lookup(req_tdata));
         end
         if (!req_tvalid || req_tready) begin
            if (address_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= address_backlog.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      lookup_result_type want;
      lookup_result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[11:0];
            if (predicted_lookups.size() == 0) begin
               $display("%0t: unexpected response item, actual %h", $realtime, rsp_tdata);
               error_count++;
            end else begin
               want = predicted_lookups.pop_front();
               if (got.hit !== want.hit || got.way !== want.way ||
                   got.set_index !== want.set_index || rsp_tdata[15:12] !== 4'd0) begin
                  $display("%0t: mismatch, expected hit %b way %0d set %0d, actual %h",
                           $realtime, want.hit, want.way, want.set_index, rsp_tdata);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("tb_set_assoc_cache_clock_replace: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_INDEX_BITS:  cfg_index_bits = val;
         REG_OFFSET_BITS: cfg_offset_bits = val;
         REG_WAYS_IN_USE: cfg_ways = val;
         default: ;
      endcase
   endtask

   task automatic wait_until_drained();
      do @(posedge clock);
      while (address_backlog.size() > 0 || req_tvalid || predicted_lookups.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes a configuration, then sends random items biased toward a few tags in a few sets.
   task automatic run_segment(input logic [3:0] ib, input logic [3:0] ob, input logic [3:0] ways,
                              input int send_pct, input int recv_pct, input int count);
      logic [31:0] addr;
      logic [31:0] tag_part;
      logic [31:0] set_part;
      int unsigned shift;
      write_csr(REG_INDEX_BITS, ib);
      write_csr(REG_OFFSET_BITS, ob);
      write_csr(REG_WAYS_IN_USE, ways);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      shift = active_index_bits() + cfg_offset_bits;
      for (int i = 0; i < count; i++) begin
         addr = $urandom();
         if ($urandom_range(9) < 7) begin
            tag_part = $urandom_range(active_ways() + 3);
            set_part = $urandom_range(3);
            set_part = (set_part & ((32'd1 << active_index_bits()) - 1)) << cfg_offset_bits;
            addr = (tag_part << shift) | set_part | (addr & ((32'd1 << cfg_offset_bits) - 1));
         end
         address_backlog.push_back(addr);
      end
      wait_until_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed items under the reset configuration: extremes, hits, and a full clock sweep
      // of set zero where every way is referenced when the fifth tag arrives.
      send_idle_pct = 26;
      recv_idle_pct = 71;
      address_backlog = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                          32'h0000_1000, 32'h0000_2000, 32'h0000_3000, 32'h0000_4000,
                          32'h0000_1000, 32'h0000_5000, 32'h0000_2000, 32'h0000_0000,
                          32'h7FFF_FFFF, 32'h0000_003F, 32'h0000_0FC0, 32'hAAAA_AAAA,
                          32'h5555_5555, 32'hFFFF_F000, 32'hFFFF_FFC0, 32'h0000_4010};
      wait_until_drained();

      run_segment(4'd2,  4'd4,  4'd4,  26, 71, 160);
      run_segment(4'd0,  4'd0,  4'd1,  26, 71, 160);
      run_segment(4'd8,  4'd12, 4'd8,  26, 71, 160);
      run_segment(4'd15, 4'd15, 4'd8,  71, 26, 160);
      // Fewer ways than before leaves some hands past the ways in use.
      run_segment(4'd3,  4'd6,  4'd2,  71, 26, 160);
      run_segment(4'd1,  4'd2,  4'd0,  71, 26, 160);
      run_segment(4'd4,  4'd5,  4'd15, 0,  0,  160);
      run_segment(4'd2,  4'd3,  4'd3,  0,  0,  160);
      run_segment(4'd6,  4'd6,  4'd4,  0,  0,  160);

      if (error_count == 0) begin
         $display("tb_set_assoc_cache_clock_replace: clean");
      end else begin
         $display("tb_set_assoc_cache_clock_replace: errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/sacc_pkg.sv
rtl/sacc_ram.sv
rtl/sacc_probe.sv
rtl/set_assoc_cache_clock_replace.sv
tb/sv/tb_set_assoc_cache_clock_replace.sv
